/* sv/bfb_pkg.sv */
// Shared types and constants of the page frame buffer with line drawing.
package bfb_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;
  localparam int ROWS_PER_PAGE = 8;
  localparam int EPS_W       = 11;

  localparam logic [1:0] ACT_DRAW  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLOT_RD,
    ST_PLOT_WR,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    LM_VERT,
    LM_HORIZ,
    LM_XMAJ,
    LM_YMAJ
  } line_mode_t;

  typedef struct packed {
    logic load;
    logic step;
  } walk_ctl_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic       last;
  } pix_t;

endpackage

/* sv/bfb_if.sv */
// Valid/ready channels for command words and result words.
interface bfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] x_start;
  logic [7:0] y_start;
  logic [7:0] x_end;
  logic [7:0] y_end;
  logic       ink;
  logic [2:0] read_page;
  logic [6:0] read_column;

  modport source (
    output valid, action, x_start, y_start, x_end, y_end, ink, read_page, read_column,
    input  ready
  );
  modport sink (
    input  valid, action, x_start, y_start, x_end, y_end, ink, read_page, read_column,
    output ready
  );
endinterface

interface bfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

/* sv/bfb_ram.sv */
// Generic simple dual-port RAM with registered read.
module bfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/bfb_line_walker.sv */
// Line walker: steps through the pixels of a line, one pixel per step.
module bfb_line_walker
  import bfb_pkg::*;
(
  input  logic       clk,
  input  walk_ctl_t  ctl,
  input  logic [7:0] x_start,
  input  logic [7:0] y_start,
  input  logic [7:0] x_end,
  input  logic [7:0] y_end,
  output pix_t       pix
);

  line_mode_t               mode;
  logic [7:0]               x_cur, y_cur, x_lim, y_lim;
  logic [7:0]               maj_d, min_d;
  logic                     x_neg, y_neg;
  logic signed [EPS_W-1:0]  eps;

  logic [7:0]               x_step, y_step;
  logic signed [EPS_W-1:0]  eps_sum;
  logic                     minor_move;
  logic [7:0]               dx, dy;
  logic                     is_vert, is_horiz;

  assign x_step     = x_neg ? x_cur - 8'd1 : x_cur + 8'd1;
  assign y_step     = y_neg ? y_cur - 8'd1 : y_cur + 8'd1;
  assign eps_sum    = eps + $signed({3'd0, min_d});
  assign minor_move = $signed({eps_sum, 1'b0}) >= $signed({4'd0, maj_d});

  assign dx       = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
  assign dy       = (y_end >= y_start) ? y_end - y_start : y_start - y_end;
  assign is_vert  = (x_start == x_end);
  assign is_horiz = !is_vert && (y_start == y_end);

  always_comb begin
    pix.x = x_cur;
    pix.y = y_cur;
    case (mode)
      LM_VERT:  pix.last = (y_cur == y_lim);
      LM_HORIZ: pix.last = (x_cur == x_lim);
      LM_XMAJ:  pix.last = (x_step == x_lim);
      LM_YMAJ:  pix.last = (y_step == y_lim);
      default:  pix.last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_neg <= (x_end < x_start);
      y_neg <= (y_end < y_start);
      eps   <= '0;
      x_lim <= x_end;
      y_lim <= y_end;
      x_cur <= x_start;
      y_cur <= y_start;
      if (is_vert) begin
        mode  <= LM_VERT;
        y_cur <= (y_start < y_end) ? y_start : y_end;
        y_lim <= (y_start < y_end) ? y_end : y_start;
      end else if (is_horiz) begin
        mode  <= LM_HORIZ;
        x_cur <= (x_start < x_end) ? x_start : x_end;
        x_lim <= (x_start < x_end) ? x_end : x_start;
      end else if (dx > dy) begin
        mode  <= LM_XMAJ;
        maj_d <= dx;
        min_d <= dy;
      end else begin
        mode  <= LM_YMAJ;
        maj_d <= dy;
        min_d <= dx;
      end
    end else if (ctl.step) begin
      case (mode)
        LM_VERT:  y_cur <= y_cur + 8'd1;
        LM_HORIZ: x_cur <= x_cur + 8'd1;
        LM_XMAJ: begin
          x_cur <= x_step;
          if (minor_move) begin
            y_cur <= y_step;
            eps   <= eps_sum - $signed({3'd0, maj_d});
          end else begin
            eps   <= eps_sum;
          end
        end
        LM_YMAJ: begin
          y_cur <= y_step;
          if (minor_move) begin
            x_cur <= x_step;
            eps   <= eps_sum - $signed({3'd0, maj_d});
          end else begin
            eps   <= eps_sum;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/bresenham_line_framebuffer.sv */
// Top level: page frame buffer with line drawing, clear and byte read-back.
//
// The picture is PAGES pages of COLUMNS bytes in one RAM; bit n of a byte is
// row page*8+n. One command word at a time is worked on, and each gives one
// result word (the byte for a read, zero otherwise). Every on-picture pixel
// of a line is a read-modify-write of its byte through the single RAM write
// port; off-picture pixels are dropped without a RAM access. A clear writes
// one byte per cycle. After reset the block runs a clearing pass over all
// PAGES*COLUMNS bytes (1024 at the default size) with cmd.ready low. A new
// command is taken while the previous result still waits in the output
// register.
module bresenham_line_framebuffer
  import bfb_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int PAGES   = PAGES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bfb_cmd_if.sink   cmd,
  bfb_rsp_if.source rsp
);

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  state_t          state, state_next;
  logic [AW-1:0]   clr_addr;
  logic            clr_item;
  logic            rd_hit;
  logic            ink;
  logic            rsp_valid;
  logic [7:0]      rsp_data;

  walk_ctl_t       walk;
  pix_t            pix;
  logic            pix_in;
  logic [AW-1:0]   pix_addr;
  logic [AW-1:0]   rd_addr;
  logic            rd_in;
  logic [7:0]      pix_mask;

  logic            accept;
  logic            slot_free;
  logic            push;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;

  bfb_line_walker u_walker (
    .clk     (clk),
    .ctl     (walk),
    .x_start (cmd.x_start),
    .y_start (cmd.y_start),
    .x_end   (cmd.x_end),
    .y_end   (cmd.y_end),
    .pix     (pix)
  );

  bfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept    = cmd.valid && cmd.ready;
  assign slot_free = !rsp_valid || rsp.ready;

  assign pix_in   = ({1'b0, pix.x} < 9'(COLUMNS)) && ({1'b0, pix.y} < 9'(PAGES * ROWS_PER_PAGE));
  assign pix_addr = AW'(({11'd0, pix.y[7:3]} * 16'(COLUMNS)) + {8'd0, pix.x});
  assign pix_mask = 8'd1 << pix.y[2:0];

  assign rd_in   = ({6'd0, cmd.read_page} < 9'(PAGES)) && ({2'd0, cmd.read_column} < 9'(COLUMNS));
  assign rd_addr = AW'(({13'd0, cmd.read_page} * 16'(COLUMNS)) + {9'd0, cmd.read_column});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == CLR_LAST) begin
          state_next = clr_item ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd.action)
            ACT_DRAW:  state_next = ST_PLOT_RD;
            ACT_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_PLOT_RD: begin
        if (pix_in) begin
          state_next = ST_PLOT_WR;
        end else if (pix.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_PLOT_WR: state_next = pix.last ? ST_FINISH : ST_PLOT_RD;
      ST_FINISH:  state_next = slot_free ? ST_IDLE : ST_FINISH;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.ready = 1'b0;
    walk      = '0;
    ram_we    = 1'b0;
    ram_waddr = pix_addr;
    ram_wdata = ink ? (ram_rdata & ~pix_mask) : (ram_rdata | pix_mask);
    ram_re    = 1'b0;
    ram_raddr = pix_addr;
    push      = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        cmd.ready = 1'b1;
        walk.load = cmd.valid && (cmd.action == ACT_DRAW);
        ram_re    = cmd.valid && (cmd.action == ACT_READ);
        ram_raddr = rd_addr;
      end
      ST_PLOT_RD: begin
        ram_re    = pix_in;
        walk.step = !pix_in;
      end
      ST_PLOT_WR: begin
        ram_we    = 1'b1;
        walk.step = 1'b1;
      end
      ST_FINISH: push = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      clr_item  <= 1'b0;
      rd_hit    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (accept) begin
        clr_addr <= '0;
        clr_item <= (cmd.action == ACT_CLEAR);
        rd_hit   <= (cmd.action == ACT_READ) && rd_in;
      end
      if (push) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ink <= cmd.ink;
    end
    if (push) begin
      rsp_data <= rd_hit ? ram_rdata : 8'd0;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = rsp_data;

endmodule

/* sv/bfb_checker.sv */
// Port-level checks of the frame buffer, bound to the top level.
module bfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] read_data
);

  // the clearing pass after reset holds off commands
  a_reset_clear: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("command taken right after reset");

  // one command in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("second command taken while one is in flight");

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(read_data)))
    else $error("stalled result word changed or dropped");

endmodule

bind bresenham_line_framebuffer bfb_checker u_bfb_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .read_data (rsp.read_data)
);

/* bench/tb_bresenham_line_framebuffer.sv */
// Self-checking bench for the page frame buffer: line draws, clears and byte read-back.
module tb_bresenham_line_framebuffer;
  timeunit 1ns;
  timeprecision 1ps;
  import bfb_pkg::*;

  localparam int COLS           = 128;
  localparam int NUM_PAGES      = 8;
  localparam int ROWS           = NUM_PAGES * ROWS_PER_PAGE;
  localparam int FRAME_BYTES    = NUM_PAGES * COLS;
  localparam int RANDOM_WORDS   = 575;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 120;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] action;
    logic [7:0] xs;
    logic [7:0] ys;
    logic [7:0] xe;
    logic [7:0] ye;
    logic       ink;
    logic [2:0] page;
    logic [6:0] col;
    bit         drain_first;
  } cmd_word_t;

  logic clk;
  logic rst;

  bfb_cmd_if cmd_if ();
  bfb_rsp_if rsp_if ();

  bresenham_line_framebuffer u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  cmd_word_t  pending_q[$];
  cmd_word_t  offered;
  logic [7:0] expected_bytes[$];
  logic [7:0] frame_model [0:FRAME_BYTES-1];

  int n_accepted = 0;
  int n_results  = 0;
  int n_errors   = 0;
  int n_draws    = 0;
  int n_clears   = 0;
  int n_reads    = 0;
  int n_unused   = 0;
  int hold_left  = 0;
  bit hold_done  = 0;
  int stuck_cycles = 0;
  int last_x = 0;
  int last_y = 0;

  // frame predictor ---------------------------------------------------------

  function automatic void set_pixel(int x, int y, logic ink);
    int idx;
    if (x < 0 || x >= COLS || y < 0 || y >= ROWS) return;
    idx = (y / ROWS_PER_PAGE) * COLS + x;
    frame_model[idx][y % ROWS_PER_PAGE] = ~ink;
  endfunction

  function automatic void trace_line(int x1, int y1, int x2, int y2, logic ink);
    int dx, dy, ux, uy, x, y, err, lo, hi;
    if (x1 == x2) begin
      lo = (y1 < y2) ? y1 : y2;
      hi = (y1 < y2) ? y2 : y1;
      for (int k = lo; k <= hi; k++) set_pixel(x1, k, ink);
    end else if (y1 == y2) begin
      lo = (x1 < x2) ? x1 : x2;
      hi = (x1 < x2) ? x2 : x1;
      for (int k = lo; k <= hi; k++) set_pixel(k, y1, ink);
    end else begin
      dx = x2 - x1;
      dy = y2 - y1;
      ux = (dx > 0) ? 1 : -1;
      uy = (dy > 0) ? 1 : -1;
      x = x1;
      y = y1;
      err = 0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      // the walk stops one step short of the far endpoint
      if (dx > dy) begin
        while (x != x2) begin
          set_pixel(x, y, ink);
          err += dy;
          if (err * 2 >= dx) begin
            y += uy;
            err -= dx;
          end
          x += ux;
        end
      end else begin
        while (y != y2) begin
          set_pixel(x, y, ink);
          err += dx;
          if (err * 2 >= dy) begin
            x += ux;
            err -= dy;
          end
          y += uy;
        end
      end
    end
  endfunction

  function automatic logic [7:0] predict_byte(cmd_word_t w);
    logic [7:0] data;
    data = 8'h00;
    case (w.action)
      ACT_DRAW: begin
        trace_line(int'(w.xs), int'(w.ys), int'(w.xe), int'(w.ye), w.ink);
        n_draws++;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < FRAME_BYTES; i++) frame_model[i] = 8'h00;
        n_clears++;
      end
      ACT_READ: begin
        data = frame_model[int'(w.page) * COLS + int'(w.col)];
        n_reads++;
      end
      default: n_unused++;
    endcase
    return data;
  endfunction

  // stimulus builders --------------------------------------------------------

  function automatic void queue_word(logic [1:0] action, int xs, int ys, int xe, int ye,
                                     logic ink, int page, int col, bit drain_first = 0);
    cmd_word_t w;
    w.action      = action;
    w.xs          = 8'(xs);
    w.ys          = 8'(ys);
    w.xe          = 8'(xe);
    w.ye          = 8'(ye);
    w.ink         = ink;
    w.page        = 3'(page);
    w.col         = 7'(col);
    w.drain_first = drain_first;
    pending_q.push_back(w);
  endfunction

  function automatic int near(int v);
    int lo, hi;
    lo = (v < 16) ? 0 : v - 16;
    hi = (v > 239) ? 255 : v + 16;
    return $urandom_range(hi, lo);
  endfunction

  function automatic void queue_random_word(bit drain_first);
    int r, m, xs, ys, xe, ye, page, col;
    logic ink;
    r    = $urandom_range(99);
    xs   = $urandom_range(255);
    ys   = $urandom_range(255);
    xe   = $urandom_range(255);
    ye   = $urandom_range(255);
    ink  = ($urandom_range(99) < 25);
    page = $urandom_range(7);
    col  = $urandom_range(127);
    if (r < 55) begin
      m = $urandom_range(9);
      if (m < 8) begin
        xs = $urandom_range(COLS - 1);
        ys = $urandom_range(ROWS - 1);
      end
      if (m < 4) begin
        xe = $urandom_range(COLS - 1);
        ye = $urandom_range(ROWS - 1);
      end else if (m < 7) begin
        xe = near(xs);
        ye = near(ys);
      end else if (m == 9) begin
        // straight line, possibly running off the picture
        if ($urandom_range(1)) xe = xs;
        else ye = ys;
      end
      if (xs < COLS && ys < ROWS) begin
        last_x = xs;
        last_y = ys;
      end
      queue_word(ACT_DRAW, xs, ys, xe, ye, ink, page, col, drain_first);
    end else if (r < 58) begin
      queue_word(ACT_CLEAR, xs, ys, xe, ye, ink, page, col, drain_first);
    end else if (r < 60) begin
      queue_word(ACT_UNUSED, xs, ys, xe, ye, ink, page, col, drain_first);
    end else begin
      // aim most reads at the byte under a recently drawn start point
      if ($urandom_range(99) < 60) begin
        page = last_y / ROWS_PER_PAGE;
        col  = last_x;
      end
      queue_word(ACT_READ, xs, ys, xe, ye, ink, page, col, drain_first);
    end
  endfunction

  // traffic shaping: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
  function automatic int traffic_mode();
    return (n_accepted / 40) % 4;
  endfunction

  function automatic bit sender_idle();
    case (traffic_mode())
      1:       return ($urandom_range(99) < 66);
      3:       return ($urandom_range(99) < 7);
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (traffic_mode())
      2:       return ($urandom_range(99) < 66);
      3:       return ($urandom_range(99) < 7);
      default: return 1'b0;
    endcase
  endfunction

  // clock --------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // command driver -----------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        expected_bytes.push_back(predict_byte(offered));
        n_accepted++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_q.size() > 0 && !sender_idle() &&
            !(pending_q[0].drain_first && expected_bytes.size() > 0)) begin
          offered = pending_q.pop_front();
          cmd_if.valid       <= 1'b1;
          cmd_if.action      <= offered.action;
          cmd_if.x_start     <= offered.xs;
          cmd_if.y_start     <= offered.ys;
          cmd_if.x_end       <= offered.xe;
          cmd_if.y_end       <= offered.ye;
          cmd_if.ink         <= offered.ink;
          cmd_if.read_page   <= offered.page;
          cmd_if.read_column <= offered.col;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor -----------------------------------------------------------

  always @(posedge clk) begin : result_monitor
    logic [7:0] want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_results++;
        if (expected_bytes.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, actual %02h",
                   $time, rsp_if.read_data);
          n_errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (rsp_if.read_data !== want) begin
            $display("%0t ns: read_data mismatch, expected %02h, actual %02h",
                     $time, want, rsp_if.read_data);
            n_errors++;
          end
        end
      end
      // one long hold-off so the block backs up and stalls its command side
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && n_results >= HOLD_AFTER) begin
        hold_done    <= 1'b1;
        hold_left    <= LONG_HOLD;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !receiver_stall();
      end
    end
  end

  // watchdog -----------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, stuck_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // stimulus and end of run --------------------------------------------------

  initial begin
    rst                = 1'b1;
    cmd_if.valid       = 1'b0;
    cmd_if.action      = ACT_DRAW;
    cmd_if.x_start     = '0;
    cmd_if.y_start     = '0;
    cmd_if.x_end       = '0;
    cmd_if.y_end       = '0;
    cmd_if.ink         = 1'b0;
    cmd_if.read_page   = '0;
    cmd_if.read_column = '0;
    rsp_if.ready       = 1'b0;
    for (int i = 0; i < FRAME_BYTES; i++) frame_model[i] = 8'h00;

    // single point, then a full-height vertical line and a line along the bottom edge
    queue_word(ACT_DRAW, 0, 0, 0, 0, 1'b0, 0, 0);
    queue_word(ACT_READ, 0, 0, 0, 0, 1'b0, 0, 0);
    queue_word(ACT_DRAW, 5, 63, 5, 0, 1'b0, 0, 0);
    queue_word(ACT_READ, 255, 255, 255, 255, 1'b1, 7, 5);
    queue_word(ACT_DRAW, 127, 63, 0, 63, 1'b0, 0, 0);
    queue_word(ACT_READ, 0, 0, 0, 0, 1'b0, 7, 127);
    // straight lines running to 255 must not wrap
    queue_word(ACT_DRAW, 120, 10, 255, 10, 1'b0, 0, 0);
    queue_word(ACT_READ, 0, 0, 0, 0, 1'b0, 1, 127);
    queue_word(ACT_DRAW, 3, 60, 3, 255, 1'b0, 0, 0);
    queue_word(ACT_READ, 0, 0, 0, 0, 1'b0, 7, 3);
    // major-axis walks in both directions
    queue_word(ACT_DRAW, 0, 0, 127, 20, 1'b0, 0, 0);
    queue_word(ACT_READ, 0, 0, 0, 0, 1'b0, 1, 60);
    queue_word(ACT_DRAW, 100, 63, 90, 0, 1'b0, 0, 0);
    queue_word(ACT_READ, 0, 0, 0, 0, 1'b0, 3, 95);
    // wholly and partly off the picture
    queue_word(ACT_DRAW, 255, 255, 130, 200, 1'b0, 7, 127);
    queue_word(ACT_DRAW, 200, 70, 20, 5, 1'b0, 0, 0);
    queue_word(ACT_READ, 0, 0, 0, 0, 1'b0, 0, 20);
    // erase ink over an inked column
    queue_word(ACT_DRAW, 5, 0, 5, 63, 1'b1, 0, 0);
    queue_word(ACT_READ, 0, 0, 0, 0, 1'b0, 7, 5);
    queue_word(ACT_UNUSED, 255, 255, 255, 255, 1'b1, 7, 127);
    queue_word(ACT_READ, 0, 0, 0, 0, 1'b0, 0, 0, 1'b1);
    queue_word(ACT_CLEAR, 0, 0, 0, 0, 1'b0, 0, 0);
    queue_word(ACT_READ, 0, 0, 0, 0, 1'b0, 7, 127);
    queue_word(ACT_DRAW, 10, 10, 40, 40, 1'b0, 0, 0);
    queue_word(ACT_READ, 0, 0, 0, 0, 1'b0, 1, 10);

    for (int i = 0; i < RANDOM_WORDS; i++) queue_random_word(i % 97 == 96);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 0 || cmd_if.valid) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d line draws, %0d frame clears, %0d byte reads, %0d unused words",
             n_draws, n_clears, n_reads, n_unused);
    $display("Checked %0d result words, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/bfb_pkg.sv
sv/bfb_if.sv
sv/bfb_ram.sv
sv/bfb_line_walker.sv
sv/bresenham_line_framebuffer.sv
sv/bfb_checker.sv
bench/tb_bresenham_line_framebuffer.sv
